FILE: hw/rtl/uks_pkg.sv
// ----------------------------------------------------------------------------
// uks_pkg
// Shared types and codes for the unique key stack unit.
// ----------------------------------------------------------------------------
`default_nettype none

package uks_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ENTRY_W  = KEY_W + DATA_W;
  localparam int unsigned OPC_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [OPC_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OPC_W-1:0] OP_POP  = 2'd1;
  localparam logic [OPC_W-1:0] OP_PEEK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVER  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic [OPC_W-1:0]         opcode;
    logic signed [KEY_W-1:0]  push_key;
    logic signed [DATA_W-1:0] push_data;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [KEY_W-1:0]  top_key;
    logic signed [DATA_W-1:0] top_data;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
  } rsp_t;

  typedef struct packed {
    logic req_ready;
    logic rsp_valid;
  } hs_t;

endpackage

`default_nettype wire

FILE: hw/rtl/uks_chan_if.sv
// ----------------------------------------------------------------------------
// uks_chan_if
// Request and response channels of the unique key stack unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface uks_req_if;
  logic                                    valid;
  logic                                    ready;
  logic [uks_pkg::OPC_W-1:0]               opcode;
  logic signed [uks_pkg::KEY_W-1:0]        push_key;
  logic signed [uks_pkg::DATA_W-1:0]       push_data;

  modport source (output valid, output opcode, output push_key, output push_data,
                  input ready);
  modport sink   (input valid, input opcode, input push_key, input push_data,
                  output ready);
endinterface

interface uks_rsp_if;
  logic                                    valid;
  logic                                    ready;
  logic [uks_pkg::STATUS_W-1:0]            status;
  logic signed [uks_pkg::KEY_W-1:0]        top_key;
  logic signed [uks_pkg::DATA_W-1:0]       top_data;
  logic [uks_pkg::COUNT_W-1:0]             entry_count;
  logic                                    is_empty;

  modport source (output valid, output status, output top_key, output top_data,
                  output entry_count, output is_empty, input ready);
  modport sink   (input valid, input status, input top_key, input top_data,
                  input entry_count, input is_empty, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/uks_ram.sv
// ----------------------------------------------------------------------------
// uks_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module uks_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/uks_seq.sv
// ----------------------------------------------------------------------------
// uks_seq
// Request sequencer: depth counter, key scan with one shared comparator,
// entry write and top-of-stack read.
// ----------------------------------------------------------------------------
`default_nettype none

module uks_seq #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                req_valid,
  input  wire uks_pkg::req_t                       req,
  input  wire logic                                rsp_take,
  output uks_pkg::hs_t                             hs,
  output uks_pkg::rsp_t                            rsp,
  output logic                                     ram_we,
  output logic [$clog2(STACK_DEPTH)-1:0]           ram_waddr,
  output logic [uks_pkg::ENTRY_W-1:0]              ram_wdata,
  output logic                                     ram_re,
  output logic [$clog2(STACK_DEPTH)-1:0]           ram_raddr,
  input  wire logic [uks_pkg::ENTRY_W-1:0]         ram_rdata
);

  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EXT_W = CNT_W + uks_pkg::COUNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_TOPRD = 3'd3;
  localparam logic [2:0] S_TOPCP = 3'd4;
  localparam logic [2:0] S_HOLD  = 3'd5;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

  logic [2:0]                       state_r, state_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [CNT_W-1:0]                 idx_r, idx_nxt;
  logic                             pend_r, pend_nxt;
  logic [uks_pkg::KEY_W-1:0]        key_r, key_nxt;
  logic [uks_pkg::DATA_W-1:0]       data_r, data_nxt;
  logic [uks_pkg::STATUS_W-1:0]     status_r, status_nxt;
  uks_pkg::rsp_t                    rsp_r, rsp_nxt;
  logic [CNT_W-1:0]                 top_idx;
  logic [EXT_W-1:0]                 cnt_ext;
  logic                             key_hit;

  assign top_idx = cnt_r - CNT_W'(1);
  assign cnt_ext = EXT_W'(cnt_r);
  assign key_hit = pend_r && (ram_rdata[uks_pkg::ENTRY_W-1:uks_pkg::DATA_W] == key_r);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    pend_nxt   = 1'b0;
    key_nxt    = key_r;
    data_nxt   = data_r;
    status_nxt = status_r;
    rsp_nxt    = rsp_r;
    ram_we     = 1'b0;
    ram_waddr  = cnt_r[AW-1:0];
    ram_wdata  = {key_r, data_r};
    ram_re     = 1'b0;
    ram_raddr  = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          key_nxt    = req.push_key;
          data_nxt   = req.push_data;
          status_nxt = uks_pkg::ST_DONE;
          idx_nxt    = '0;
          unique case (req.opcode)
            uks_pkg::OP_PUSH: begin
              state_nxt = S_SCAN;
            end
            uks_pkg::OP_POP: begin
              state_nxt = S_TOPRD;
              if (cnt_r == '0) begin
                status_nxt = uks_pkg::ST_UNDER;
              end else begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            default: begin
              state_nxt = S_TOPRD;
              if (cnt_r == '0) begin
                status_nxt = uks_pkg::ST_EMPTY;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        priority if (key_hit) begin
          status_nxt = uks_pkg::ST_DUP;
          state_nxt  = S_TOPRD;
        end else if (idx_r == cnt_r) begin
          if (cnt_r == FULL_CNT) begin
            status_nxt = uks_pkg::ST_OVER;
            state_nxt  = S_TOPRD;
          end else begin
            state_nxt = S_WRITE;
          end
        end else begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + CNT_W'(1);
        end
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_TOPRD;
      end
      S_TOPRD: begin
        ram_re    = (cnt_r != '0);
        ram_raddr = top_idx[AW-1:0];
        state_nxt = S_TOPCP;
      end
      S_TOPCP: begin
        rsp_nxt.status      = status_r;
        rsp_nxt.entry_count = cnt_ext[uks_pkg::COUNT_W-1:0];
        rsp_nxt.is_empty    = (cnt_r == '0);
        if (cnt_r == '0) begin
          rsp_nxt.top_key  = '0;
          rsp_nxt.top_data = '0;
        end else begin
          rsp_nxt.top_key  = ram_rdata[uks_pkg::ENTRY_W-1:uks_pkg::DATA_W];
          rsp_nxt.top_data = ram_rdata[uks_pkg::DATA_W-1:0];
        end
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (rsp_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
    rsp_r    <= rsp_nxt;
  end

  assign hs.req_ready = (state_r == S_IDLE);
  assign hs.rsp_valid = (state_r == S_HOLD);
  assign rsp          = rsp_r;

endmodule

`default_nettype wire

FILE: hw/rtl/unique_key_stack_unit.sv
// ----------------------------------------------------------------------------
// unique_key_stack_unit
// Last-in first-out store of key and data pairs that refuses duplicate keys.
// ----------------------------------------------------------------------------
// Each request beat (push, pop, peek; opcode 3 acts as peek) yields one
// response beat with status, top pair, entry count and empty flag. A push
// scans the held keys one per cycle through the store's single read port and
// one comparator, then writes the new pair unless the store is full or a
// duplicate key is found; every request then reads the top entry and copies
// it into the response. A finished response sits in an output register, so
// the next request is taken while it waits. Stored entries need no clearing
// after reset.
`default_nettype none

module unique_key_stack_unit #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  uks_req_if.sink    in_req,
  uks_rsp_if.source  out_rsp
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  uks_pkg::req_t              req;
  uks_pkg::rsp_t              rsp;
  uks_pkg::hs_t               hs;
  logic                       rsp_take;
  logic                       out_vld_r, out_vld_nxt;
  uks_pkg::rsp_t              out_data_r;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [uks_pkg::ENTRY_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [uks_pkg::ENTRY_W-1:0] ram_rdata;

  assign req.opcode    = in_req.opcode;
  assign req.push_key  = in_req.push_key;
  assign req.push_data = in_req.push_data;

  uks_seq #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_req.valid),
    .req       (req),
    .rsp_take  (rsp_take),
    .hs        (hs),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  uks_ram #(
    .WIDTH (uks_pkg::ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rsp_take = hs.rsp_valid && (!out_vld_r || out_rsp.ready);

  always_comb begin
    out_vld_nxt = out_vld_r;
    priority if (rsp_take) begin
      out_vld_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      out_data_r <= rsp;
    end
  end

  assign in_req.ready        = hs.req_ready;
  assign out_rsp.valid       = out_vld_r;
  assign out_rsp.status      = out_data_r.status;
  assign out_rsp.top_key     = out_data_r.top_key;
  assign out_rsp.top_data    = out_data_r.top_data;
  assign out_rsp.entry_count = out_data_r.entry_count;
  assign out_rsp.is_empty    = out_data_r.is_empty;

endmodule

`default_nettype wire
